@@ rtl/core/task_timeout_budget_table_defines.svh @@
`ifndef TASK_TIMEOUT_BUDGET_TABLE_DEFINES_SVH
`define TASK_TIMEOUT_BUDGET_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, quiet during reset
`define TTBT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ttbt check failed");

// next-cycle implication, sampled on clk_i, quiet during reset
`define TTBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ttbt check failed");

`endif

@@ rtl/core/ttbt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ttbt_pkg;

  localparam int unsigned ENTRIES = 16;

  localparam logic [47:0] BUDGET_MAX = 48'h7FFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_UPDATE = 2'd2,
    FUNC_LOOKUP = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_DUP     = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_MISSING = 2'd3
  } status_e;

  typedef struct packed {
    func_e              func;
    logic [63:0]        task_key;
    logic signed [47:0] initial_budget;
    logic [47:0]        start_stamp;
    logic signed [31:0] tmo_setting;
    logic [47:0]        now_stamp;
  } in_t;

  typedef struct packed {
    logic               found;
    status_e            status;
    logic signed [47:0] budget_out;
    logic [47:0]        stamp_out;
    logic               timed_out;
  } out_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_ADD,
    CMD_REMOVE,
    CMD_UPDATE
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e            op;
    logic [63:0]        key;
    logic signed [47:0] budget;
    logic [47:0]        stamp;
  } cmd_t;

  typedef struct packed {
    logic               hit;
    logic               free;
    logic signed [47:0] budget;
    logic [47:0]        stamp;
  } link_t;

endpackage

`default_nettype wire

@@ rtl/core/ttbt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ttbt_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ttbt_pkg::cmd_t cmd_i,
  input  wire ttbt_pkg::link_t link_i,
  output ttbt_pkg::link_t     link_o
);
  import ttbt_pkg::*;

  logic               valid_q;
  logic               sel_q;
  logic               alloc_q;
  logic [63:0]        key_q;
  logic signed [47:0] budget_q;
  logic [47:0]        stamp_q;
  logic               match;
  logic               take_free;

  assign match     = valid_q && (key_q == cmd_i.key);
  assign take_free = !valid_q && !link_i.free;

  always_comb begin
    link_o.hit    = link_i.hit | match;
    link_o.free   = link_i.free | !valid_q;
    link_o.budget = link_i.budget | (match ? budget_q : '0);
    link_o.stamp  = link_i.stamp | (match ? stamp_q : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
      alloc_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        CMD_LATCH: begin
          sel_q   <= match;
          alloc_q <= take_free;
        end
        CMD_ADD: begin
          if (alloc_q) begin
            valid_q <= 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (sel_q) begin
            valid_q <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_ADD && alloc_q) begin
      key_q    <= cmd_i.key;
      budget_q <= cmd_i.budget;
      stamp_q  <= cmd_i.stamp;
    end else if (cmd_i.op == CMD_UPDATE && sel_q) begin
      budget_q <= cmd_i.budget;
      stamp_q  <= cmd_i.stamp;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ttbt_chain.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ttbt_chain (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ttbt_pkg::cmd_t cmd_i,
  output ttbt_pkg::link_t     tail_o
);
  import ttbt_pkg::*;

  link_t links [ENTRIES+1];

  assign links[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    ttbt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd_i),
      .link_i (links[g]),
      .link_o (links[g+1])
    );
  end

  assign tail_o = links[ENTRIES];

endmodule

`default_nettype wire

@@ rtl/core/task_timeout_budget_table.sv @@
// Keyed timeout table: up to ENTRIES entries, each a 64-bit task key with a
// signed 48-bit budget and a 48-bit last-update stamp, held in a row of cells.
// Input channel: in_valid_i / in_stall_o carry one operation per transaction
// (add, remove, update budget, lookup). Output channel: out_valid_o /
// out_stall_i carry exactly one result per input transaction, in order.
// Sequence: after acceptance the operation passes through LOOK and EXEC; the
// result is registered when EXEC completes. No new input is taken until then;
// LOOK broadcasts the key along the cell row (match, lowest free slot, entry
// read), and EXEC applies the change and the budget arithmetic.
// A waiting result sits in the output register; the next input is accepted
// meanwhile, and the operation holds in its final step while the receiver
// stalls and the output register is still full.
// Reset clears all entries and both valid flags at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "task_timeout_budget_table_defines.svh"

module task_timeout_budget_table (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire ttbt_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output ttbt_pkg::out_t      out_data_o
);
  import ttbt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EXEC
  } state_e;

  state_e             state_q;
  logic               out_valid_q;
  in_t                item_q;
  link_t              look_q;
  out_t               out_q;
  link_t              tail;
  cmd_t               cmd;
  out_t               res;
  logic               accept;
  logic               fire;
  logic               tmo_active;
  logic [49:0]        rem;
  logic signed [47:0] new_budget;

  assign accept = in_valid_i && !in_stall_o;
  assign fire   = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  ttbt_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .tail_o (tail)
  );

  assign tmo_active = (item_q.tmo_setting != '0) && !item_q.tmo_setting[31];

  always_comb begin
    rem = {{2{look_q.budget[47]}}, look_q.budget} - {2'b00, item_q.now_stamp}
          + {2'b00, look_q.stamp};
    if (rem[49] || rem == '0) begin
      new_budget = '0;
    end else if (rem[48:47] != 2'b00) begin
      new_budget = BUDGET_MAX;
    end else begin
      new_budget = rem[47:0];
    end
  end

  always_comb begin
    cmd.op     = CMD_NONE;
    cmd.key    = item_q.task_key;
    cmd.budget = item_q.initial_budget;
    cmd.stamp  = item_q.start_stamp;
    res        = '0;
    res.status = STATUS_OK;

    case (item_q.func)
      FUNC_ADD: begin
        if (look_q.hit) begin
          res.status     = STATUS_DUP;
          res.found      = 1'b1;
          res.budget_out = look_q.budget;
          res.stamp_out  = look_q.stamp;
        end else if (!look_q.free) begin
          res.status = STATUS_FULL;
        end else begin
          cmd.op         = CMD_ADD;
          res.found      = 1'b1;
          res.budget_out = item_q.initial_budget;
          res.stamp_out  = item_q.start_stamp;
        end
      end
      FUNC_REMOVE: begin
        if (look_q.hit) begin
          cmd.op = CMD_REMOVE;
        end else begin
          res.status = STATUS_MISSING;
        end
      end
      FUNC_UPDATE: begin
        if (!look_q.hit) begin
          res.status = STATUS_MISSING;
        end else if (tmo_active) begin
          cmd.op         = CMD_UPDATE;
          cmd.budget     = new_budget;
          cmd.stamp      = item_q.now_stamp;
          res.found      = 1'b1;
          res.budget_out = new_budget;
          res.stamp_out  = item_q.now_stamp;
        end else begin
          res.found      = 1'b1;
          res.budget_out = look_q.budget;
          res.stamp_out  = look_q.stamp;
        end
      end
      default: begin
        if (look_q.hit) begin
          res.found      = 1'b1;
          res.budget_out = look_q.budget;
          res.stamp_out  = look_q.stamp;
        end else begin
          res.status = STATUS_MISSING;
        end
      end
    endcase

    res.timed_out = res.found && (res.budget_out == '0);

    if (state_q == ST_LOOK) begin
      cmd.op = CMD_LATCH;
    end else if (!fire) begin
      cmd.op = CMD_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (fire) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_LOOK) begin
      look_q <= tail;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  `TTBT_ASSERT_NEXT(a_busy_after_accept, accept, in_stall_o)
  `TTBT_ASSERT_NOW(a_missing_zero, out_valid_o && !out_data_o.found,
                   out_data_o.budget_out == '0 && out_data_o.stamp_out == '0
                   && !out_data_o.timed_out)
  `TTBT_ASSERT_NOW(a_dup_found, out_valid_o && out_data_o.status == STATUS_DUP, out_data_o.found)
  `TTBT_ASSERT_NEXT(a_result_held, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

endmodule

`default_nettype wire
